// File: src/rbu_pkg.sv
// shared types, constants and helper functions of the raw bayer byte unpacker
package rbu_pkg;

  localparam int unsigned COUNT_BITS_DEFAULT  = 32;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PIX_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned MAX_PIX     = 4;
  localparam int unsigned PIX_IDX_W   = $clog2(MAX_PIX);
  localparam int unsigned PIX_CNT_W   = $clog2(MAX_PIX + 2);
  localparam int unsigned GROUP_DEPTH = 6;
  localparam int unsigned GROUP_IDX_W = $clog2(GROUP_DEPTH + 1);
  localparam int unsigned ACC_W       = 24;
  localparam int unsigned BIT_FILL_W  = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CSI2_MODE   = 2'd0,
    CFG_WIDTH_SEL   = 2'd1,
    CFG_FRONT_SKIP  = 2'd2,
    CFG_PIXEL_LIMIT = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    WIDTH_10 = 2'd0,
    WIDTH_12 = 2'd1,
    WIDTH_14 = 2'd2,
    WIDTH_16 = 2'd3
  } width_sel_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_PARTIAL = 2'd1,
    STATUS_SHORT   = 2'd2
  } status_e;

  typedef struct packed {
    logic [MAX_PIX-1:0][PIX_W-1:0] pix;
    logic [PIX_CNT_W-1:0]          cnt;
    logic                          has_status;
    status_e                       code;
  } rec_t;

  function automatic logic [GROUP_IDX_W-1:0] group_need(input width_sel_e sel);
    logic [GROUP_IDX_W-1:0] need;
    unique case (sel)
      WIDTH_10: need = GROUP_IDX_W'(5);
      WIDTH_12: need = GROUP_IDX_W'(3);
      WIDTH_14: need = GROUP_IDX_W'(7);
      WIDTH_16: need = GROUP_IDX_W'(2);
    endcase
    return need;
  endfunction

  function automatic logic [BIT_FILL_W-1:0] pix_bits(input width_sel_e sel);
    logic [BIT_FILL_W-1:0] w;
    unique case (sel)
      WIDTH_10: w = BIT_FILL_W'(10);
      WIDTH_12: w = BIT_FILL_W'(12);
      WIDTH_14: w = BIT_FILL_W'(14);
      WIDTH_16: w = BIT_FILL_W'(16);
    endcase
    return w;
  endfunction

  function automatic logic [PIX_W-1:0] pix_mask(input width_sel_e sel);
    logic [PIX_W-1:0] m;
    unique case (sel)
      WIDTH_10: m = PIX_W'(16'h03FF);
      WIDTH_12: m = PIX_W'(16'h0FFF);
      WIDTH_14: m = PIX_W'(16'h3FFF);
      WIDTH_16: m = PIX_W'(16'hFFFF);
    endcase
    return m;
  endfunction

endpackage

// File: src/rbu_front.sv
// front end: configuration, skip, group collection, bit unpacking and pixel limit
module rbu_front #(
  parameter int unsigned COUNT_BITS = rbu_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rbu_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rbu_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             accept_i,
  input  logic [rbu_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic                             last_byte_i,
  output logic                             rec_valid_o,
  output rbu_pkg::rec_t                    rec_o
);

  localparam int unsigned CMP_W = (COUNT_BITS > rbu_pkg::CFG_DATA_W) ?
                                  COUNT_BITS : rbu_pkg::CFG_DATA_W;
  localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'({COUNT_BITS{1'b1}});
  localparam int unsigned CNT_W = rbu_pkg::PIX_CNT_W;
  localparam int unsigned GI_W  = rbu_pkg::GROUP_IDX_W;
  localparam int unsigned PW    = rbu_pkg::PIX_W;
  localparam int unsigned NP    = rbu_pkg::MAX_PIX;

  logic                                csi2_mode_q;
  rbu_pkg::width_sel_e                 width_sel_q;
  logic [rbu_pkg::CFG_DATA_W-1:0]      front_skip_q;
  logic [rbu_pkg::CFG_DATA_W-1:0]      pixel_limit_q;

  logic [rbu_pkg::BYTE_W-1:0]          group_store_q [rbu_pkg::GROUP_DEPTH];
  logic [GI_W-1:0]                     group_fill_q, group_fill_d;
  logic [rbu_pkg::ACC_W-1:0]           acc_q, acc_d;
  logic [rbu_pkg::BIT_FILL_W-1:0]      bit_fill_q, bit_fill_d;
  logic [COUNT_BITS-1:0]               skipped_q, skipped_d;
  logic [COUNT_BITS-1:0]               sent_q, sent_d;

  logic                                skipping;
  logic [GI_W-1:0]                     need;
  logic                                csi_done;
  logic [rbu_pkg::ACC_W-1:0]           low14;
  logic [NP-1:0][PW-1:0]               csi_pix;
  logic [CNT_W-1:0]                    csi_n;

  logic [rbu_pkg::BIT_FILL_W-1:0]      w, fill0, fill1, fill2;
  logic [PW-1:0]                       mask;
  logic [rbu_pkg::ACC_W-1:0]           acc_ins, acc1, acc2;
  logic                                emit0, emit1;

  logic [NP-1:0][PW-1:0]               raw_pix;
  logic [CNT_W-1:0]                    raw_n;

  logic [CMP_W-1:0]                    limit_ext, sent_ext, gap;
  logic                                limit_on, unreach, sent_lt, gap_big, short_run;
  logic [CNT_W-1:0]                    gap_lo, kept;
  logic [COUNT_BITS-1:0]               sent_sum [NP+1];
  logic [COUNT_BITS:0]                 sum_ext  [NP+1];
  logic [GI_W-1:0]                     fill_after;
  rbu_pkg::status_e                    code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csi2_mode_q   <= 1'b1;
      width_sel_q   <= rbu_pkg::WIDTH_10;
      front_skip_q  <= '0;
      pixel_limit_q <= '0;
    end else if (cfg_we_i) begin
      unique case (rbu_pkg::cfg_idx_e'(cfg_index_i))
        rbu_pkg::CFG_CSI2_MODE:   csi2_mode_q   <= cfg_wdata_i[0];
        rbu_pkg::CFG_WIDTH_SEL:   width_sel_q   <= rbu_pkg::width_sel_e'(cfg_wdata_i[1:0]);
        rbu_pkg::CFG_FRONT_SKIP:  front_skip_q  <= cfg_wdata_i;
        rbu_pkg::CFG_PIXEL_LIMIT: pixel_limit_q <= cfg_wdata_i;
      endcase
    end
  end

  assign skipping = CMP_W'(skipped_q) < CMP_W'(front_skip_q);

  // csi-2 group decode
  assign need     = rbu_pkg::group_need(width_sel_q);
  assign csi_done = group_fill_q >= (need - GI_W'(1));
  assign low14    = {data_byte_i, group_store_q[5], group_store_q[4]};

  always_comb begin
    csi_pix = '0;
    csi_n   = '0;
    unique case (width_sel_q)
      rbu_pkg::WIDTH_10: begin
        for (int i = 0; i < 4; i++) begin
          csi_pix[i] = PW'({group_store_q[i], data_byte_i[2*i +: 2]});
        end
        csi_n = CNT_W'(4);
      end
      rbu_pkg::WIDTH_12: begin
        csi_pix[0] = PW'({group_store_q[0], data_byte_i[3:0]});
        csi_pix[1] = PW'({group_store_q[1], data_byte_i[7:4]});
        csi_n      = CNT_W'(2);
      end
      rbu_pkg::WIDTH_14: begin
        for (int i = 0; i < 4; i++) begin
          csi_pix[i] = PW'({group_store_q[i], low14[6*i +: 6]});
        end
        csi_n = CNT_W'(4);
      end
      rbu_pkg::WIDTH_16: begin
        csi_pix[0] = PW'({data_byte_i, group_store_q[0]});
        csi_n      = CNT_W'(1);
      end
    endcase
  end

  // compact lsb-first unpack, at most two pixels per byte
  assign w       = rbu_pkg::pix_bits(width_sel_q);
  assign mask    = rbu_pkg::pix_mask(width_sel_q);
  assign acc_ins = acc_q | (rbu_pkg::ACC_W'(data_byte_i) << bit_fill_q);
  assign fill0   = bit_fill_q + rbu_pkg::BIT_FILL_W'(8);
  assign emit0   = fill0 >= w;
  assign acc1    = acc_ins >> w;
  assign fill1   = fill0 - w;
  assign emit1   = emit0 && (fill1 >= w);
  assign acc2    = acc1 >> w;
  assign fill2   = fill1 - w;

  always_comb begin
    raw_pix = '0;
    raw_n   = '0;
    if (skipping) begin
      raw_n = '0;
    end else if (csi2_mode_q) begin
      raw_pix = csi_pix;
      raw_n   = csi_done ? csi_n : '0;
    end else begin
      raw_pix[0] = acc_ins[PW-1:0] & mask;
      raw_pix[1] = acc1[PW-1:0] & mask;
      raw_n      = emit1 ? CNT_W'(2) : (emit0 ? CNT_W'(1) : '0);
    end
  end

  // pixel limit
  assign limit_ext = CMP_W'(pixel_limit_q);
  assign sent_ext  = CMP_W'(sent_q);
  assign limit_on  = pixel_limit_q != '0;
  assign unreach   = limit_ext > COUNT_MAX;
  assign sent_lt   = sent_ext < limit_ext;
  assign gap       = limit_ext - sent_ext;
  assign gap_big   = |gap[CMP_W-1:CNT_W];
  assign gap_lo    = gap[CNT_W-1:0];

  always_comb begin
    if (!limit_on || unreach) begin
      kept = raw_n;
    end else if (!sent_lt) begin
      kept = '0;
    end else if (gap_big || gap_lo >= raw_n) begin
      kept = raw_n;
    end else begin
      kept = gap_lo;
    end
  end

  assign short_run = limit_on && (unreach || (sent_lt && (gap_big || gap_lo > kept)));

  always_comb begin
    for (int j = 0; j <= NP; j++) begin
      sum_ext[j]  = {1'b0, sent_q} + (COUNT_BITS + 1)'(j);
      sent_sum[j] = sum_ext[j][COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum_ext[j][COUNT_BITS-1:0];
    end
  end

  assign fill_after = (skipping || !csi2_mode_q) ? group_fill_q :
                      (csi_done ? '0 : group_fill_q + GI_W'(1));

  always_comb begin
    if (limit_on) begin
      code = short_run ? rbu_pkg::STATUS_SHORT : rbu_pkg::STATUS_OK;
    end else if (csi2_mode_q && fill_after != '0) begin
      code = rbu_pkg::STATUS_PARTIAL;
    end else begin
      code = rbu_pkg::STATUS_OK;
    end
  end

  // next run state
  always_comb begin
    group_fill_d = group_fill_q;
    acc_d        = acc_q;
    bit_fill_d   = bit_fill_q;
    skipped_d    = skipped_q;
    sent_d       = sent_sum[kept];
    if (skipping) begin
      skipped_d = (skipped_q == {COUNT_BITS{1'b1}}) ? skipped_q : skipped_q + COUNT_BITS'(1);
    end else if (csi2_mode_q) begin
      group_fill_d = fill_after;
    end else begin
      acc_d      = emit1 ? acc2 : (emit0 ? acc1 : acc_ins);
      bit_fill_d = emit1 ? fill2 : (emit0 ? fill1 : fill0);
    end
    if (last_byte_i) begin
      group_fill_d = '0;
      acc_d        = '0;
      bit_fill_d   = '0;
      skipped_d    = '0;
      sent_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_fill_q <= '0;
      acc_q        <= '0;
      bit_fill_q   <= '0;
      skipped_q    <= '0;
      sent_q       <= '0;
    end else if (accept_i) begin
      group_fill_q <= group_fill_d;
      acc_q        <= acc_d;
      bit_fill_q   <= bit_fill_d;
      skipped_q    <= skipped_d;
      sent_q       <= sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !skipping && csi2_mode_q && !csi_done) begin
      group_store_q[group_fill_q] <= data_byte_i;
    end
  end

  assign rec_valid_o     = accept_i && ((kept != '0) || last_byte_i);
  assign rec_o.pix       = raw_pix;
  assign rec_o.cnt       = kept;
  assign rec_o.has_status = last_byte_i;
  assign rec_o.code      = code;

endmodule

// File: src/rbu_queue.sv
// short record queue between the front and back ends
module rbu_queue #(
  parameter int unsigned DEPTH = rbu_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  rbu_pkg::rec_t wr_data_i,
  output logic          full_o,
  input  logic          rd_en_i,
  output logic          rd_valid_o,
  output rbu_pkg::rec_t rd_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  rbu_pkg::rec_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_wr, do_rd;

  assign full_o     = count_q == CNT_W'(DEPTH);
  assign rd_valid_o = count_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_en_i && !full_o;
  assign do_rd      = rd_en_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

// File: src/rbu_back.sv
// back end: walks each record and sends its beats through the output register
module rbu_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rec_valid_i,
  input  rbu_pkg::rec_t               rec_i,
  output logic                        rec_pop_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [rbu_pkg::PIX_W-1:0]   pixel_value_o,
  output logic                        is_status_o,
  output logic [1:0]                  status_code_o,
  output logic                        end_of_run_o
);

  localparam int unsigned CNT_W = rbu_pkg::PIX_CNT_W;

  logic                      out_valid_q;
  logic [CNT_W-1:0]          idx_q;
  logic [CNT_W-1:0]          idx_inc, total;
  logic                      is_pix, load, rec_last;
  logic [rbu_pkg::PIX_W-1:0] pix_q;
  logic                      stat_q, eor_q;
  rbu_pkg::status_e          code_q;

  assign total    = rec_i.cnt + CNT_W'(rec_i.has_status);
  assign idx_inc  = idx_q + CNT_W'(1);
  assign rec_last = idx_inc == total;
  assign is_pix   = idx_q < rec_i.cnt;
  assign load     = rec_valid_i && (!out_valid_q || pop_i);
  assign rec_pop_o = load && rec_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= rec_last ? '0 : idx_inc;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q  <= is_pix ? rec_i.pix[idx_q[rbu_pkg::PIX_IDX_W-1:0]] : '0;
      stat_q <= !is_pix;
      code_q <= is_pix ? rbu_pkg::STATUS_OK : rec_i.code;
      eor_q  <= rec_last;
    end
  end

  assign empty_o       = !out_valid_q;
  assign pixel_value_o = pix_q;
  assign is_status_o   = stat_q;
  assign status_code_o = code_q;
  assign end_of_run_o  = eor_q;

endmodule

// File: src/raw_bayer_byte_unpacker_unit.sv
// top level of the raw bayer byte unpacker
//
// Input side is a queue write port: a byte beat (data_byte_i, last_byte_i)
// is taken on a clock edge with push high and full low. Result side is a
// queue read port: while empty is low the oldest beat sits on pixel_value_o,
// is_status_o, status_code_o and end_of_run_o and leaves on an edge with pop
// high. The config port writes register cfg_index_i with cfg_wdata_i on any
// edge with cfg_we_i high; users must use it only while the block is idle,
// which the block does not enforce. One byte is taken per cycle while full
// is low. The front end handles a byte in the cycle it is taken and hands
// its pixels and status as one record to a queue of QUEUE_DEPTH records; the
// back end sends one beat per cycle from it unless stalled. full rises only
// when the queue is full, which happens when results outpace pops.
// Reset restores the default config, clears the run counters and empties the
// queue and output register; the group store is not cleared. If the receiver
// stops popping, the output holds, the queue fills and then full goes high.
module raw_bayer_byte_unpacker_unit #(
  parameter int unsigned COUNT_BITS  = rbu_pkg::COUNT_BITS_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = rbu_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rbu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rbu_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           push,
  output logic                           full,
  input  logic [rbu_pkg::BYTE_W-1:0]     data_byte_i,
  input  logic                           last_byte_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [rbu_pkg::PIX_W-1:0]      pixel_value_o,
  output logic                           is_status_o,
  output logic [1:0]                     status_code_o,
  output logic                           end_of_run_o
);

  logic          accept;
  logic          rec_valid;
  rbu_pkg::rec_t rec_wr, rec_rd;
  logic          rec_rd_valid, rec_pop;

  assign accept = push && !full;

  rbu_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .rec_valid_o (rec_valid),
    .rec_o       (rec_wr)
  );

  rbu_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (rec_valid),
    .wr_data_i  (rec_wr),
    .full_o     (full),
    .rd_en_i    (rec_pop),
    .rd_valid_o (rec_rd_valid),
    .rd_data_o  (rec_rd)
  );

  rbu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_valid_i   (rec_rd_valid),
    .rec_i         (rec_rd),
    .rec_pop_o     (rec_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .pixel_value_o (pixel_value_o),
    .is_status_o   (is_status_o),
    .status_code_o (status_code_o),
    .end_of_run_o  (end_of_run_o)
  );

endmodule

// File: src/rbu_checker.sv
// port checker for the raw bayer byte unpacker and its bind
module rbu_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         empty,
  input logic                         pop,
  input logic [rbu_pkg::PIX_W-1:0]    pixel_value_i,
  input logic                         is_status_i,
  input logic [1:0]                   status_code_i,
  input logic                         end_of_run_i
);

  a_status_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && is_status_i |-> end_of_run_i)
    else $error("status beat without end of run");

  a_status_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && is_status_i |-> pixel_value_i == '0)
    else $error("status beat carries a pixel value");

  a_pixel_code_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !is_status_i |-> status_code_i == rbu_pkg::STATUS_OK)
    else $error("pixel beat carries a status code");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(pixel_value_i) && $stable(is_status_i)
      && $stable(status_code_i) && $stable(end_of_run_i))
    else $error("stalled result beat changed");

endmodule

bind raw_bayer_byte_unpacker_unit rbu_checker u_rbu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .pixel_value_i (pixel_value_o),
  .is_status_i   (is_status_o),
  .status_code_i (status_code_o),
  .end_of_run_i  (end_of_run_o)
);

// File: dv/tb_raw_bayer_byte_unpacker_unit.sv
`timescale 1ns / 1ps
// testbench of the raw bayer byte unpacker: directed table, random images, beat scoreboard
module tb_raw_bayer_byte_unpacker_unit;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_BYTES = 260;
  localparam int unsigned SETTLE       = 16;
  localparam int unsigned SCRIPT_LEN   = 35;

  typedef enum logic {
    ROW_BYTE,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    logic [rbu_pkg::PIX_W-1:0] pix;
    logic                      st;
    rbu_pkg::status_e          code;
    logic                      eor;
  } beat_t;

  typedef struct packed {
    row_kind_e         kind;
    rbu_pkg::cfg_idx_e sel;
    logic [31:0]       value;
    logic              last;
    logic              typed;
    beat_t             want;
  } stim_row_t;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [rbu_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [rbu_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                           push        = 1'b0;
  logic                           full;
  logic [rbu_pkg::BYTE_W-1:0]     data_byte_i = '0;
  logic                           last_byte_i = 1'b0;
  logic                           empty;
  logic                           pop         = 1'b0;
  logic [rbu_pkg::PIX_W-1:0]      pixel_value_o;
  logic                           is_status_o;
  logic [1:0]                     status_code_o;
  logic                           end_of_run_o;

  raw_bayer_byte_unpacker_unit dut (.*);

  always #6 clk_i = ~clk_i;

  // unpacker state as the block should hold it
  logic                 cfg_csi2  = 1'b1;
  rbu_pkg::width_sel_e  cfg_width = rbu_pkg::WIDTH_10;
  logic [31:0]          cfg_skip  = '0;
  logic [31:0]          cfg_limit = '0;
  logic [7:0]           grp [rbu_pkg::GROUP_DEPTH];
  logic [2:0]           grp_fill  = '0;
  logic [23:0]          bit_acc   = '0;
  logic [4:0]           bit_cnt   = '0;
  logic [31:0]          skip_cnt  = '0;
  logic [31:0]          pix_sent  = '0;

  beat_t       awaited_beats [$];
  int          step_beats;
  int          mismatches  = 0;
  int          pop_hold    = 0;
  int unsigned cycle_cnt   = 0;
  bit          calm        = 1'b0;

  function automatic int draw_wait();
    return calm ? 0 : int'($urandom_range(0, 11));
  endfunction

  function automatic int group_len(input rbu_pkg::width_sel_e sel);
    case (sel)
      rbu_pkg::WIDTH_10: return 5;
      rbu_pkg::WIDTH_12: return 3;
      rbu_pkg::WIDTH_14: return 7;
      default:           return 2;
    endcase
  endfunction

  function automatic void append_beat(input beat_t bt);
    awaited_beats.insert(awaited_beats.size(), bt);
  endfunction

  function automatic void emit_pixel(input logic [rbu_pkg::PIX_W-1:0] value);
    if (cfg_limit == 0 || pix_sent < cfg_limit) begin
      if (pix_sent != '1) pix_sent++;
      append_beat('{value, 1'b0, rbu_pkg::STATUS_OK, 1'b0});
      step_beats++;
    end
  endfunction

  // returns 1 when the byte was unpacked rather than skipped
  function automatic logic unpack_byte(input logic [7:0] b, input logic last);
    int               w;
    logic [23:0]      low;
    logic [31:0]      acc;
    rbu_pkg::status_e code;
    beat_t            tail;
    logic             took;
    took       = 1'b1;
    step_beats = 0;
    if (skip_cnt < cfg_skip) begin
      if (skip_cnt != '1) skip_cnt++;
      took = 1'b0;
    end else if (cfg_csi2) begin
      if (int'(grp_fill) + 1 < group_len(cfg_width)) begin
        grp[grp_fill] = b;
        grp_fill++;
      end else begin
        grp_fill = '0;
        case (cfg_width)
          rbu_pkg::WIDTH_10: begin
            for (int i = 0; i < 4; i++) emit_pixel(16'({grp[i], b[2*i +: 2]}));
          end
          rbu_pkg::WIDTH_12: begin
            emit_pixel(16'({grp[0], b[3:0]}));
            emit_pixel(16'({grp[1], b[7:4]}));
          end
          rbu_pkg::WIDTH_14: begin
            low = {b, grp[5], grp[4]};
            for (int i = 0; i < 4; i++) emit_pixel(16'({grp[i], low[6*i +: 6]}));
          end
          default: emit_pixel({b, grp[0]});
        endcase
      end
    end else begin
      w       = 10 + 2 * int'(cfg_width);
      acc     = ({8'h00, bit_acc} | (32'(b) << bit_cnt)) & 32'h00FF_FFFF;
      bit_acc = acc[23:0];
      bit_cnt += 5'd8;
      while (int'(bit_cnt) >= w) begin
        emit_pixel(16'(bit_acc & ((24'd1 << w) - 24'd1)));
        bit_acc >>= w;
        bit_cnt -= 5'(w);
      end
    end
    if (last) begin
      code = rbu_pkg::STATUS_OK;
      if (cfg_limit != 0) begin
        if (pix_sent < cfg_limit) code = rbu_pkg::STATUS_SHORT;
      end else if (cfg_csi2 && grp_fill != 0) begin
        code = rbu_pkg::STATUS_PARTIAL;
      end
      append_beat('{16'h0000, 1'b1, code, 1'b0});
      step_beats++;
      grp_fill = '0;
      bit_acc  = '0;
      bit_cnt  = '0;
      skip_cnt = '0;
      pix_sent = '0;
    end
    if (step_beats > 0) begin
      tail     = awaited_beats.pop_back();
      tail.eor = 1'b1;
      append_beat(tail);
    end
    return took;
  endfunction

  function automatic stim_row_t cfg_row(input rbu_pkg::cfg_idx_e sel,
                                        input logic [31:0] value);
    return '{ROW_CFG, sel, value, 1'b0, 1'b0, '0};
  endfunction

  function automatic stim_row_t byte_row(input logic [7:0] b, input logic last);
    return '{ROW_BYTE, rbu_pkg::CFG_CSI2_MODE, 32'(b), last, 1'b0, '0};
  endfunction

  function automatic stim_row_t typed_row(input logic [7:0] b, input logic last,
                                          input logic [rbu_pkg::PIX_W-1:0] pix,
                                          input logic st,
                                          input rbu_pkg::status_e code);
    return '{ROW_BYTE, rbu_pkg::CFG_CSI2_MODE, 32'(b), last, 1'b1, '{pix, st, code, 1'b1}};
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last, output logic took);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (full);
    took = unpack_byte(b, last);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input rbu_pkg::cfg_idx_e sel, input logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sel;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (sel)
      rbu_pkg::CFG_CSI2_MODE:  cfg_csi2 = value[0];
      rbu_pkg::CFG_WIDTH_SEL:  cfg_width = rbu_pkg::width_sel_e'(value[1:0]);
      rbu_pkg::CFG_FRONT_SKIP: cfg_skip = value;
      default:                 cfg_limit = value;
    endcase
  endtask

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (awaited_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat with nothing awaited: pix %h st %b code %0d end %b",
                     pixel_value_o, is_status_o, status_code_o, end_of_run_o);
        end else begin
          want = awaited_beats.pop_front();
          if (pixel_value_o !== want.pix || is_status_o !== want.st ||
              status_code_o !== want.code || end_of_run_o !== want.eor) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch pix/st/code/end: exp %h/%b/%0d/%b got %h/%b/%0d/%b",
                       want.pix, want.st, want.code, want.eor,
                       pixel_value_o, is_status_o, status_code_o, end_of_run_o);
          end
        end
        pop_hold = draw_wait();
        if (pop_hold > 0) pop <= 1'b0;
      end else if (!pop) begin
        if (pop_hold > 0) pop_hold--;
        if (pop_hold == 0) pop <= 1'b1;
      end
    end
  end

  initial begin
    stim_row_t   script [SCRIPT_LEN];
    logic        took;
    logic        ends;
    logic        mid_image;
    logic [7:0]  b;
    logic [31:0] value;
    int          unpacked;
    int          nbytes;
    int          gsize;
    int          pick;
    int          wr_odds;
    script = '{
      byte_row(8'hFF, 1'b0), byte_row(8'hFF, 1'b0), byte_row(8'hFF, 1'b0),
      byte_row(8'hFF, 1'b0), typed_row(8'hFF, 1'b0, 16'h03FF, 1'b0, rbu_pkg::STATUS_OK),
      byte_row(8'h00, 1'b0),
      typed_row(8'h00, 1'b1, 16'h0000, 1'b1, rbu_pkg::STATUS_PARTIAL),
      cfg_row(rbu_pkg::CFG_WIDTH_SEL, 32'(rbu_pkg::WIDTH_16)),
      byte_row(8'hFF, 1'b0), typed_row(8'hFF, 1'b0, 16'hFFFF, 1'b0, rbu_pkg::STATUS_OK),
      byte_row(8'h34, 1'b0), byte_row(8'h12, 1'b1),
      cfg_row(rbu_pkg::CFG_WIDTH_SEL, 32'(rbu_pkg::WIDTH_14)),
      cfg_row(rbu_pkg::CFG_PIXEL_LIMIT, 32'd3),
      byte_row(8'h80, 1'b0), byte_row(8'h7F, 1'b0), byte_row(8'h01, 1'b0),
      byte_row(8'hFE, 1'b0), byte_row(8'hC3, 1'b0), byte_row(8'h3C, 1'b0),
      byte_row(8'h96, 1'b1),
      cfg_row(rbu_pkg::CFG_CSI2_MODE, 32'd0),
      cfg_row(rbu_pkg::CFG_WIDTH_SEL, 32'(rbu_pkg::WIDTH_12)),
      cfg_row(rbu_pkg::CFG_PIXEL_LIMIT, 32'd0),
      byte_row(8'hFF, 1'b0), byte_row(8'h0F, 1'b1),
      cfg_row(rbu_pkg::CFG_FRONT_SKIP, 32'd2), cfg_row(rbu_pkg::CFG_PIXEL_LIMIT, 32'd4),
      byte_row(8'hAA, 1'b0), byte_row(8'hBB, 1'b0), byte_row(8'h11, 1'b0),
      typed_row(8'h22, 1'b1, 16'h0000, 1'b1, rbu_pkg::STATUS_SHORT),
      cfg_row(rbu_pkg::CFG_FRONT_SKIP, 32'hFFFF_FFFF),
      cfg_row(rbu_pkg::CFG_PIXEL_LIMIT, 32'hFFFF_FFFF),
      typed_row(8'h5A, 1'b1, 16'h0000, 1'b1, rbu_pkg::STATUS_SHORT)
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(script[i].sel, script[i].value);
      end else begin
        send_byte(script[i].value[7:0], script[i].last, took);
        if (script[i].typed) begin
          void'(awaited_beats.pop_back());
          append_beat(script[i].want);
        end
      end
    end

    unpacked  = 0;
    mid_image = 1'b0;
    while (unpacked < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 3) == 0);
      wait_idle();
      wr_odds = mid_image ? 2 : 3;
      if ($urandom_range(0, 3) < wr_odds) write_reg(rbu_pkg::CFG_CSI2_MODE, $urandom);
      if ($urandom_range(0, 3) < wr_odds) write_reg(rbu_pkg::CFG_WIDTH_SEL, $urandom);
      if ($urandom_range(0, 3) < wr_odds) begin
        pick  = $urandom_range(0, 15);
        value = pick == 0 ? 32'hFFFF_FFFF : pick == 1 ? $urandom :
                pick < 9 ? 32'd0 : 32'($urandom_range(1, 3));
        write_reg(rbu_pkg::CFG_FRONT_SKIP, value);
      end
      if ($urandom_range(0, 3) < wr_odds) begin
        pick  = $urandom_range(0, 15);
        value = pick == 0 ? 32'hFFFF_FFFF : pick < 8 ? 32'd0 : 32'($urandom_range(1, 10));
        write_reg(rbu_pkg::CFG_PIXEL_LIMIT, value);
      end

      gsize = group_len(cfg_width);
      if (cfg_csi2) begin
        nbytes = gsize * $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0) nbytes += $urandom_range(1, gsize - 1);
      end else begin
        nbytes = $urandom_range(1, 14);
      end
      if (cfg_skip < 8 && !mid_image) nbytes += int'(cfg_skip);
      ends = ($urandom_range(0, 7) != 0);
      for (int i = 0; i < nbytes; i++) begin
        pick = $urandom_range(0, 15);
        b    = pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom);
        send_byte(b, (ends && i == nbytes - 1) || $urandom_range(0, 63) == 0, took);
        if (took) unpacked++;
      end
      mid_image = !ends;
    end

    wait_idle();
    mismatches += awaited_beats.size();
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
